FILE: hdl/fpos_pkg.sv
// Shared constants and types for the fixed predictor order selector.
// No dependencies; every other file imports this package.
package fpos_pkg;

	localparam int DEF_SAMPLE_BITS = 24;
	localparam int DEF_ACC_BITS    = 48;

	localparam int NUM_ORDERS = 5;
	localparam int ORDER_BITS = 3;
	localparam int HIST_DEPTH = NUM_ORDERS - 1;
	localparam int COUNT_BITS = 3;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef logic [ORDER_BITS-1:0] order_t;

	localparam order_t ORD_0 = 3'd0;
	localparam order_t ORD_1 = 3'd1;
	localparam order_t ORD_2 = 3'd2;
	localparam order_t ORD_3 = 3'd3;
	localparam order_t ORD_4 = 3'd4;

	typedef struct packed {
		logic valid;
		logic last;
		logic short_blk;
	} stage_ctl_t;

endpackage

FILE: hdl/fpos_if.sv
// Valid/ready channels for sample words in and order words out.
// Depends on fpos_pkg.
interface fpos_in_if import fpos_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

interface fpos_out_if import fpos_pkg::*;;
	logic   valid;
	logic   ready;
	order_t pred_order;

	modport source (output valid, output pred_order, input ready);
	modport sink (input valid, input pred_order, output ready);
endinterface

FILE: hdl/fpos_accum.sv
// Residual magnitude register and the five saturating order sums.
// Hands the finished sums of a block to the order select stage. Depends on fpos_pkg.
module fpos_accum import fpos_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int ACC_BITS    = DEF_ACC_BITS,
	parameter int AW          = SAMPLE_BITS + 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  stage_ctl_t          in_ctl,
	input  logic [NUM_ORDERS-1:0] in_en,
	input  logic [AW-1:0]       in_mag [NUM_ORDERS],
	output logic                in_ready,
	output stage_ctl_t          out_ctl,
	output logic [ACC_BITS-1:0] out_sums [NUM_ORDERS],
	input  logic                out_ready
);

	localparam int WW = ((ACC_BITS > AW) ? ACC_BITS : AW) + 1;

	stage_ctl_t            ctl_s2;
	logic [NUM_ORDERS-1:0] en_s2;
	logic [AW-1:0]         mag_s2 [NUM_ORDERS];
	logic [ACC_BITS-1:0]   sums_q [NUM_ORDERS];
	logic [ACC_BITS-1:0]   next_sums [NUM_ORDERS];
	stage_ctl_t            ctl_s3;
	logic [ACC_BITS-1:0]   sums_s3 [NUM_ORDERS];
	logic                  s3_free;
	logic                  drain;
	logic [WW-1:0]         wide [NUM_ORDERS];

	assign s3_free  = !ctl_s3.valid || out_ready;
	assign drain    = ctl_s2.valid && (!ctl_s2.last || s3_free);
	assign in_ready = !ctl_s2.valid || drain;

	always_comb begin
		for (int k = 0; k < NUM_ORDERS; k++) begin
			wide[k] = WW'(sums_q[k]) + WW'(mag_s2[k]);
			if (!en_s2[k]) begin
				next_sums[k] = sums_q[k];
			end else if (wide[k] > WW'({ACC_BITS{1'b1}})) begin
				next_sums[k] = '1;
			end else begin
				next_sums[k] = wide[k][ACC_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (in_ready) begin
			ctl_s2 <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_ctl.valid) begin
			en_s2  <= in_en;
			mag_s2 <= in_mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_ORDERS; k++) begin
				sums_q[k] <= '0;
			end
		end else if (drain) begin
			for (int k = 0; k < NUM_ORDERS; k++) begin
				sums_q[k] <= ctl_s2.last ? '0 : next_sums[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (s3_free) begin
			ctl_s3.valid     <= drain && ctl_s2.last;
			ctl_s3.last      <= ctl_s2.last;
			ctl_s3.short_blk <= ctl_s2.short_blk;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && drain && ctl_s2.last) begin
			sums_s3 <= next_sums;
		end
	end

	assign out_ctl  = ctl_s3;
	assign out_sums = sums_s3;

endmodule

FILE: hdl/fpos_select.sv
// Two-level minimum search over the five block sums and the result register.
// Ties go to the lower order; a short block gets order 0. Depends on fpos_pkg and fpos_out_if.
module fpos_select import fpos_pkg::*; #(
	parameter int ACC_BITS = DEF_ACC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  stage_ctl_t          in_ctl,
	input  logic [ACC_BITS-1:0] in_sums [NUM_ORDERS],
	output logic                in_ready,
	fpos_out_if.source          orders
);

	logic                v_s4;
	logic                short_s4;
	order_t              ord_a_s4;
	order_t              ord_b_s4;
	logic [ACC_BITS-1:0] sum_a_s4;
	logic [ACC_BITS-1:0] sum_b_s4;
	logic [ACC_BITS-1:0] sum_4_s4;
	logic                out_v_q;
	order_t              order_q;
	logic                out_free;
	logic                s4_free;
	order_t              pick_ab;
	logic [ACC_BITS-1:0] sum_ab;
	order_t              pick;

	assign out_free = !out_v_q || orders.ready;
	assign s4_free  = !v_s4 || out_free;
	assign in_ready = s4_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (s4_free) begin
			v_s4 <= in_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s4_free && in_ctl.valid) begin
			short_s4 <= in_ctl.short_blk;
			if (in_sums[1] < in_sums[0]) begin
				ord_a_s4 <= ORD_1;
				sum_a_s4 <= in_sums[1];
			end else begin
				ord_a_s4 <= ORD_0;
				sum_a_s4 <= in_sums[0];
			end
			if (in_sums[3] < in_sums[2]) begin
				ord_b_s4 <= ORD_3;
				sum_b_s4 <= in_sums[3];
			end else begin
				ord_b_s4 <= ORD_2;
				sum_b_s4 <= in_sums[2];
			end
			sum_4_s4 <= in_sums[4];
		end
	end

	always_comb begin
		if (sum_b_s4 < sum_a_s4) begin
			pick_ab = ord_b_s4;
			sum_ab  = sum_b_s4;
		end else begin
			pick_ab = ord_a_s4;
			sum_ab  = sum_a_s4;
		end
		if (short_s4) begin
			pick = ORD_0;
		end else if (sum_4_s4 < sum_ab) begin
			pick = ORD_4;
		end else begin
			pick = pick_ab;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s4) begin
			order_q <= pick;
		end
	end

	assign orders.valid      = out_v_q;
	assign orders.pred_order = order_q;

endmodule

FILE: hdl/fixed_predictor_order_select.sv
// Top level: fixed polynomial predictor order selection over sample blocks.
// Depends on fpos_pkg, fpos_if, fpos_accum and fpos_select.
//
//   channel   dir   payload                        word
//   samples   in    sample[SAMPLE_BITS], last      one audio sample
//   orders    out   pred_order[3]                  one per block, after last
//
// Takes one sample per cycle unless a held last sample stalls the input. A block's
// order then passes from its last sample through the input register, residual
// register, sum register, minimum search register and result register.
// Reset clears history, sample count, sums and all stage valid bits.
// A stalled result holds only the stages behind it that carry a last sample;
// samples that are not last keep draining into the sums.
module fixed_predictor_order_select import fpos_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int ACC_BITS    = DEF_ACC_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	fpos_in_if.sink    samples,
	fpos_out_if.source orders
);

	localparam int RW = SAMPLE_BITS + 5;
	localparam int AW = SAMPLE_BITS + 4;

	logic                          v_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          last_s1;
	logic signed [SAMPLE_BITS-1:0] hist_q [HIST_DEPTH];
	logic [COUNT_BITS-1:0]         count_q;
	logic                          acc_ready;
	logic                          move_s1;
	logic signed [RW-1:0]          x;
	logic signed [RW-1:0]          p1;
	logic signed [RW-1:0]          p2;
	logic signed [RW-1:0]          p3;
	logic signed [RW-1:0]          p4;
	logic signed [RW-1:0]          res [NUM_ORDERS];
	logic [AW-1:0]                 mag [NUM_ORDERS];
	logic [NUM_ORDERS-1:0]         en;
	stage_ctl_t                    ctl_in;
	stage_ctl_t                    ctl_sum;
	logic [ACC_BITS-1:0]           sums [NUM_ORDERS];
	logic                          sel_ready;

	assign samples.ready = !v_s1 || acc_ready;
	assign move_s1       = v_s1 && acc_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (samples.ready) begin
			v_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			sample_s1 <= samples.sample;
			last_s1   <= samples.last;
		end
	end

	// advance history on each sample, drop it at the end of a block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			count_q <= '0;
		end else if (move_s1) begin
			if (last_s1) begin
				for (int i = 0; i < HIST_DEPTH; i++) begin
					hist_q[i] <= '0;
				end
				count_q <= '0;
			end else begin
				hist_q[0] <= sample_s1;
				for (int i = 1; i < HIST_DEPTH; i++) begin
					hist_q[i] <= hist_q[i-1];
				end
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		x  = RW'(sample_s1);
		p1 = RW'(hist_q[0]);
		p2 = RW'(hist_q[1]);
		p3 = RW'(hist_q[2]);
		p4 = RW'(hist_q[3]);
		res[0] = x;
		res[1] = x - p1;
		res[2] = x - (p1 <<< 1) + p2;
		res[3] = x - (p1 <<< 1) - p1 + (p2 <<< 1) + p2 - p3;
		res[4] = x - (p1 <<< 2) + (p2 <<< 2) + (p2 <<< 1) - (p3 <<< 2) + p4;
		for (int k = 0; k < NUM_ORDERS; k++) begin
			mag[k] = res[k][RW-1] ? AW'(-res[k]) : AW'(res[k]);
			en[k]  = count_q >= COUNT_BITS'(k);
		end
		ctl_in.valid     = v_s1;
		ctl_in.last      = last_s1;
		ctl_in.short_blk = count_q < COUNT_BITS'(HIST_DEPTH);
	end

	fpos_accum #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.ACC_BITS   (ACC_BITS),
		.AW         (AW)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ctl   (ctl_in),
		.in_en    (en),
		.in_mag   (mag),
		.in_ready (acc_ready),
		.out_ctl  (ctl_sum),
		.out_sums (sums),
		.out_ready(sel_ready)
	);

	fpos_select #(
		.ACC_BITS(ACC_BITS)
	) u_select (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (ctl_sum),
		.in_sums (sums),
		.in_ready(sel_ready),
		.orders  (orders)
	);

	a_block_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(move_s1 && last_s1) |=> (count_q == '0 && hist_q[0] == '0))
		else $error("history not cleared after last sample");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(move_s1 && !last_s1 && count_q == COUNT_MAX) |=> (count_q == COUNT_MAX))
		else $error("sample count left saturation");

	a_order_range: assert property (@(posedge clk) disable iff (!arst_n)
		orders.valid |-> (orders.pred_order <= ORD_4))
		else $error("order out of range");

	a_short_block: assert property (@(posedge clk) disable iff (!arst_n)
		(u_select.v_s4 && u_select.short_s4 && u_select.out_free) |=>
		(orders.valid && orders.pred_order == ORD_0))
		else $error("short block did not give order zero");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Testbench for fixed_predictor_order_select: drives sample words over the input
// channel, predicts each block's best fixed order and checks every order word.
// Depends on fpos_pkg, fpos_if and the block's RTL.
module testbench;
	import fpos_pkg::*;

	localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
	localparam int ACC_BITS    = DEF_ACC_BITS;
	localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_MIN = -(64'sd1 <<< (SAMPLE_BITS - 1));
	localparam logic [63:0] SUM_MAX = {64{1'b1}} >> (64 - ACC_BITS);
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 200000;

	logic clk;
	logic arst_n;

	fpos_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) samples_if ();
	fpos_out_if orders_if ();

	fixed_predictor_order_select #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.ACC_BITS(ACC_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if),
		.orders(orders_if)
	);

	// predictor state
	longint                prev_samples [HIST_DEPTH];
	logic [COUNT_BITS-1:0] block_count;
	logic [63:0]           resid_sums [NUM_ORDERS];

	order_t expected_orders [$];
	int     errors = 0;
	int     cycles = 0;
	int     items_sent;
	int     burst_left;
	bit     gaps_on;
	bit     hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic clear_block_state();
		for (int i = 0; i < HIST_DEPTH; i++)
			prev_samples[i] = 0;
		for (int k = 0; k < NUM_ORDERS; k++)
			resid_sums[k] = '0;
		block_count = '0;
	endtask

	task automatic add_residual(input int k, input longint res);
		logic [63:0] mag;
		mag = (res < 0) ? 64'(-res) : 64'(res);
		if (mag > SUM_MAX - resid_sums[k])
			resid_sums[k] = SUM_MAX;
		else
			resid_sums[k] = resid_sums[k] + mag;
	endtask

	task automatic predict_order(input logic signed [SAMPLE_BITS-1:0] sample, input logic last);
		longint x, p1, p2, p3, p4;
		int idx;
		order_t best;
		logic [63:0] min_sum;
		x   = longint'(sample);
		p1  = prev_samples[0];
		p2  = prev_samples[1];
		p3  = prev_samples[2];
		p4  = prev_samples[3];
		idx = int'(block_count);
		add_residual(0, x);
		if (idx >= 1)
			add_residual(1, x - p1);
		if (idx >= 2)
			add_residual(2, x - 2 * p1 + p2);
		if (idx >= 3)
			add_residual(3, x - 3 * p1 + 3 * p2 - p3);
		if (idx >= 4)
			add_residual(4, x - 4 * p1 + 6 * p2 - 4 * p3 + p4);
		prev_samples[3] = p3;
		prev_samples[2] = p2;
		prev_samples[1] = p1;
		prev_samples[0] = x;
		if (block_count != COUNT_MAX)
			block_count = block_count + 1'b1;
		if (last) begin
			best = ORD_0;
			if (idx + 1 > HIST_DEPTH) begin
				min_sum = resid_sums[0];
				for (int k = 1; k < NUM_ORDERS; k++) begin
					if (resid_sums[k] < min_sum) begin
						min_sum = resid_sums[k];
						best = order_t'(k);
					end
				end
			end
			expected_orders.push_back(best);
			clear_block_state();
		end
	endtask

	task automatic send_word(input longint sample, input logic last);
		if (gaps_on && burst_left == 0) begin
			samples_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		samples_if.valid  <= 1'b1;
		samples_if.sample <= sample[SAMPLE_BITS-1:0];
		samples_if.last   <= last;
		@(posedge clk);
		while (!samples_if.ready)
			@(posedge clk);
		predict_order(sample[SAMPLE_BITS-1:0], last);
		items_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	// receiver: stall pattern of its own, plus a long hold-off on request
	initial begin
		int mode;
		int mode_left;
		orders_if.ready <= 1'b0;
		mode      = 0;
		mode_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				orders_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 128);
			end
			mode_left--;
			case (mode)
				0: begin
					orders_if.ready <= 1'b1;
				end
				1: begin
					orders_if.ready <= ($urandom_range(0, 1) == 1);
				end
				2: begin
					orders_if.ready <= (mode_left % 3 != 0);
				end
				default: begin
					orders_if.ready <= ((mode_left / 20) % 2 == 0);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && orders_if.valid && orders_if.ready) begin
			if (expected_orders.size() == 0) begin
				$error("pred_order expected none got %0d", orders_if.pred_order);
				errors++;
			end else begin
				order_t want;
				want = expected_orders.pop_front();
				if (orders_if.pred_order !== want) begin
					$error("pred_order expected %0d got %0d", want, orders_if.pred_order);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		longint alt;
		gaps_on = 1'b0;
		// single sample, short block
		send_word(SAMPLE_MIN, 1'b1);
		// four samples at the extremes, still a short block
		send_word(SAMPLE_MAX, 1'b0);
		send_word(SAMPLE_MIN, 1'b0);
		send_word(SAMPLE_MAX, 1'b0);
		send_word(SAMPLE_MIN, 1'b1);
		// ramp near full scale, orders 2 to 4 tie at zero
		for (int n = 0; n < 5; n++)
			send_word(SAMPLE_MAX - 4 + n, n == 4);
		// cubic, only order 4 reaches zero
		for (int n = 0; n < 6; n++)
			send_word(n * n * n, n == 5);
		// alternating extremes beyond the count limit
		for (int n = 0; n < 9; n++) begin
			alt = (n % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
			send_word(alt, n == 8);
		end
	endtask

	task automatic test_random_blocks(input int target);
		int len, kind, degree, pick;
		longint a, b, c, d, x;
		while (items_sent < target) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 9);
			if (pick < 2)
				len = $urandom_range(1, 4);
			else if (pick < 8)
				len = $urandom_range(5, 12);
			else
				len = $urandom_range(13, 40);
			kind   = $urandom_range(0, 9);
			degree = $urandom_range(0, 3);
			a = longint'($urandom_range(0, 2 * SAMPLE_MAX)) + SAMPLE_MIN;
			b = (degree >= 1) ? longint'($urandom_range(0, 4000)) - 2000 : 0;
			c = (degree >= 2) ? longint'($urandom_range(0, 400)) - 200 : 0;
			d = (degree >= 3) ? longint'($urandom_range(0, 40)) - 20 : 0;
			for (int n = 0; n < len; n++) begin
				if (kind < 2) begin
					x = longint'($signed($urandom() & 32'h00ff_ffff) <<< 8) >>> 8;
				end else if (kind < 6) begin
					x = a + b * n + c * n * n + d * n * n * n;
					if ($urandom_range(0, 3) == 0)
						x = x + longint'($urandom_range(0, 4)) - 2;
					if (x > SAMPLE_MAX)
						x = SAMPLE_MAX;
					if (x < SAMPLE_MIN)
						x = SAMPLE_MIN;
				end else if (kind < 8) begin
					x = ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : SAMPLE_MIN;
				end else begin
					x = longint'($urandom_range(0, 6)) - 3;
				end
				send_word(x, n == len - 1);
			end
		end
	endtask

	task automatic test_long_blocks();
		longint x;
		gaps_on = 1'b1;
		for (int blk = 0; blk < 2; blk++) begin
			for (int n = 0; n < 80; n++) begin
				x = longint'($urandom_range(0, 2000)) - 1000 + 37 * n;
				send_word(x, n == 79);
			end
		end
	endtask

	task automatic test_backpressure();
		gaps_on  = 1'b0;
		hold_req = 1'b1;
		for (int n = 0; n < 40; n++)
			send_word(longint'($urandom_range(0, 200)) - 100, 1'b1);
	endtask

	initial begin
		items_sent = 0;
		burst_left = 0;
		gaps_on    = 1'b0;
		hold_req   = 1'b0;
		clear_block_state();
		arst_n = 1'b0;
		samples_if.valid  <= 1'b0;
		samples_if.sample <= '0;
		samples_if.last   <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_blocks(1150);
		test_long_blocks();
		test_backpressure();
		test_random_blocks(1350);

		samples_if.valid <= 1'b0;
		while (expected_orders.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
